/* rtl/vector_euler_rotation_assert.svh */
// Assertion macros for the vector rotation RTL.
`ifndef VECTOR_EULER_ROTATION_ASSERT_SVH
`define VECTOR_EULER_ROTATION_ASSERT_SVH

// Check that prop holds at every clock edge outside reset.
`define VER_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that cons holds in the cycle after ante.
`define VER_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ver_pkg.sv */
// Types, constants and rounding and clamping helpers for the vector rotation pipeline.
package ver_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int CX_W         = 34;
	localparam int CZ_W         = 33;

	typedef logic signed [31:0] q30_t;

	localparam q30_t ONE30 = 32'sd1073741824;
	localparam logic signed [CX_W-1:0] CORDIC_K = 34'sd652032874;

	localparam logic [31:0] ATAN [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	// Round a Q2.60 product to Q1.30, half away from zero.
	function automatic q30_t qround(input logic signed [63:0] p);
		logic signed [63:0] r;
		begin
			r = p + 64'sd536870912 - 64'(p[63]);
			return q30_t'(r >>> 30);
		end
	endfunction

	// Clamp to the closed unit range.
	function automatic q30_t clamp_unit(input logic signed [CX_W-1:0] v);
		begin
			if (v > CX_W'(ONE30))
				return ONE30;
			else if (v < -CX_W'(ONE30))
				return -ONE30;
			else
				return q30_t'(v);
		end
	endfunction

endpackage

/* rtl/vector_euler_rotation.sv */
// Top level: Euler-angle rotation of one Q16.16 vector per transfer.
// Rotates each vector by roll, pitch and yaw and returns the saturated result.
// One transfer is taken every cycle unless an output transfer waits; the path is the
// 30-step CORDIC pipeline (32 stages), four matrix stages and three dot-product stages.
// The whole pipeline holds while an output transfer waits.
`include "vector_euler_rotation_assert.svh"

module vector_euler_rotation #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle, zero pad
	input  logic [((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// rot_x, rot_y, rot_z, zero pad
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
	import ver_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int AW    = ANGLE_WIDTH;
	localparam int OUT_W = ((3*CW+7)/8)*8;
	localparam int PW    = CW + 32;
	localparam int AW_D  = CW + 34;

	typedef logic signed [CW-1:0] coord_t;

	logic en;

	coord_t vec_x, vec_y, vec_z;
	logic [AW-1:0] roll_angle, pitch_angle, yaw_angle;

	assign vec_x       = s_axis_tdata[CW-1:0];
	assign vec_y       = s_axis_tdata[2*CW-1:CW];
	assign vec_z       = s_axis_tdata[3*CW-1:2*CW];
	assign roll_angle  = s_axis_tdata[3*CW+AW-1:3*CW];
	assign pitch_angle = s_axis_tdata[3*CW+2*AW-1:3*CW+AW];
	assign yaw_angle   = s_axis_tdata[3*CW+3*AW-1:3*CW+2*AW];

	q30_t rc, rs, pc, ps, yc, ys;

	ver_sincos #(.ANGLE_WIDTH(AW)) u_roll (
		.clk(clk), .en(en), .angle(roll_angle), .cos_o(rc), .sin_o(rs));
	ver_sincos #(.ANGLE_WIDTH(AW)) u_pitch (
		.clk(clk), .en(en), .angle(pitch_angle), .cos_o(pc), .sin_o(ps));
	ver_sincos #(.ANGLE_WIDTH(AW)) u_yaw (
		.clk(clk), .en(en), .angle(yaw_angle), .cos_o(yc), .sin_o(ys));

	// Align valid and vector with the CORDIC pipeline.
	logic   vld_c [0:CORDIC_LAT-1];
	coord_t vx_c [0:CORDIC_LAT-1];
	coord_t vy_c [0:CORDIC_LAT-1];
	coord_t vz_c [0:CORDIC_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (en) begin
			vld_c[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_c[0] <= vec_x;
			vy_c[0] <= vec_y;
			vz_c[0] <= vec_z;
		end
	end

	for (genvar k = 1; k < CORDIC_LAT; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[k] <= 1'b0;
			end else if (en) begin
				vld_c[k] <= vld_c[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				vx_c[k] <= vx_c[k-1];
				vy_c[k] <= vy_c[k-1];
				vz_c[k] <= vz_c[k-1];
			end
		end
	end

	// Matrix and dot-product stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	coord_t vx_s1, vy_s1, vz_s1, vx_s2, vy_s2, vz_s2;
	coord_t vx_s3, vy_s3, vz_s3, vx_s4, vy_s4, vz_s4;
	logic signed [63:0] ysps_s1, ycps_s1, ycrc_s1, ycrs_s1, yspc_s1;
	logic signed [63:0] rspc_s1, rcpc_s1, ysrc_s1, rsys_s1, ycpc_s1;
	q30_t rc_s1, rs_s1, ps_s1;
	q30_t t1_s2, t2_s2, ycrc_s2, ycrs_s2, yspc_s2, rspc_s2, rcpc_s2, ysrc_s2, rsys_s2;
	q30_t ycpc_s2, rc_s2, rs_s2, ps_s2;
	logic signed [63:0] t1rs_s3, t1rc_s3, t2rs_s3, t2rc_s3;
	q30_t ycrc_s3, ycrs_s3, yspc_s3, rspc_s3, rcpc_s3, ysrc_s3, rsys_s3, ycpc_s3, ps_s3;
	q30_t ent_s4 [0:8];
	logic signed [PW-1:0] px0_s5, px1_s5, px2_s5, py0_s5, py1_s5, py2_s5;
	logic signed [PW-1:0] pz0_s5, pz1_s5, pz2_s5;
	logic signed [AW_D-1:0] accx_s6, accy_s6, accz_s6;
	coord_t rot_x_s7, rot_y_s7, rot_z_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_c[CORDIC_LAT-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	function automatic coord_t sat_out(input logic signed [AW_D-1:0] acc);
		logic signed [AW_D-1:0] sh;
		logic signed [CW+3:0]   q;
		begin
			sh = acc >>> 30;
			q  = sh[CW+3:0];
			if (q[CW+3:CW-1] == '0 || q[CW+3:CW-1] == '1)
				return q[CW-1:0];
			else if (q[CW+3])
				return {1'b1, {(CW-1){1'b0}}};
			else
				return {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ysps_s1 <= ys * ps;
			ycps_s1 <= yc * ps;
			ycrc_s1 <= yc * rc;
			ycrs_s1 <= yc * rs;
			yspc_s1 <= ys * pc;
			rspc_s1 <= rs * pc;
			rcpc_s1 <= rc * pc;
			ysrc_s1 <= ys * rc;
			rsys_s1 <= rs * ys;
			ycpc_s1 <= yc * pc;
			rc_s1   <= rc;
			rs_s1   <= rs;
			ps_s1   <= ps;
			vx_s1   <= vx_c[CORDIC_LAT-1];
			vy_s1   <= vy_c[CORDIC_LAT-1];
			vz_s1   <= vz_c[CORDIC_LAT-1];

			t1_s2   <= qround(ysps_s1);
			t2_s2   <= qround(ycps_s1);
			ycrc_s2 <= qround(ycrc_s1);
			ycrs_s2 <= qround(ycrs_s1);
			yspc_s2 <= qround(yspc_s1);
			rspc_s2 <= qround(rspc_s1);
			rcpc_s2 <= qround(rcpc_s1);
			ysrc_s2 <= qround(ysrc_s1);
			rsys_s2 <= qround(rsys_s1);
			ycpc_s2 <= qround(ycpc_s1);
			rc_s2   <= rc_s1;
			rs_s2   <= rs_s1;
			ps_s2   <= ps_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			vz_s2   <= vz_s1;

			t1rs_s3 <= t1_s2 * rs_s2;
			t1rc_s3 <= t1_s2 * rc_s2;
			t2rs_s3 <= t2_s2 * rs_s2;
			t2rc_s3 <= t2_s2 * rc_s2;
			ycrc_s3 <= ycrc_s2;
			ycrs_s3 <= ycrs_s2;
			yspc_s3 <= yspc_s2;
			rspc_s3 <= rspc_s2;
			rcpc_s3 <= rcpc_s2;
			ysrc_s3 <= ysrc_s2;
			rsys_s3 <= rsys_s2;
			ycpc_s3 <= ycpc_s2;
			ps_s3   <= ps_s2;
			vx_s3   <= vx_s2;
			vy_s3   <= vy_s2;
			vz_s3   <= vz_s2;

			ent_s4[0] <= clamp_unit(CX_W'(ycrc_s3) + CX_W'(qround(t1rs_s3)));
			ent_s4[1] <= clamp_unit(-CX_W'(ycrs_s3) + CX_W'(qround(t1rc_s3)));
			ent_s4[2] <= clamp_unit(CX_W'(yspc_s3));
			ent_s4[3] <= clamp_unit(CX_W'(rspc_s3));
			ent_s4[4] <= clamp_unit(CX_W'(rcpc_s3));
			ent_s4[5] <= clamp_unit(-CX_W'(ps_s3));
			ent_s4[6] <= clamp_unit(-CX_W'(ysrc_s3) + CX_W'(qround(t2rs_s3)));
			ent_s4[7] <= clamp_unit(CX_W'(rsys_s3) + CX_W'(qround(t2rc_s3)));
			ent_s4[8] <= clamp_unit(CX_W'(ycpc_s3));
			vx_s4     <= vx_s3;
			vy_s4     <= vy_s3;
			vz_s4     <= vz_s3;

			px0_s5 <= ent_s4[0] * vx_s4;
			px1_s5 <= ent_s4[1] * vy_s4;
			px2_s5 <= ent_s4[2] * vz_s4;
			py0_s5 <= ent_s4[3] * vx_s4;
			py1_s5 <= ent_s4[4] * vy_s4;
			py2_s5 <= ent_s4[5] * vz_s4;
			pz0_s5 <= ent_s4[6] * vx_s4;
			pz1_s5 <= ent_s4[7] * vy_s4;
			pz2_s5 <= ent_s4[8] * vz_s4;

			accx_s6 <= AW_D'(px0_s5) + AW_D'(px1_s5) + AW_D'(px2_s5) + AW_D'(64'sd536870912);
			accy_s6 <= AW_D'(py0_s5) + AW_D'(py1_s5) + AW_D'(py2_s5) + AW_D'(64'sd536870912);
			accz_s6 <= AW_D'(pz0_s5) + AW_D'(pz1_s5) + AW_D'(pz2_s5) + AW_D'(64'sd536870912);

			rot_x_s7 <= sat_out(accx_s6);
			rot_y_s7 <= sat_out(accy_s6);
			rot_z_s7 <= sat_out(accz_s6);
		end
	end

	assign en            = !vld_s7 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = OUT_W'({rot_z_s7, rot_y_s7, rot_x_s7});

	`VER_ASSERT(a_entry_unit, vld_s4 |-> (ent_s4[0] <= ONE30 && ent_s4[0] >= -ONE30 && ent_s4[5] <= ONE30 && ent_s4[5] >= -ONE30), "matrix entry outside unit range")
	`VER_ASSERT(a_trig_unit, vld_c[CORDIC_LAT-1] |-> (rc <= ONE30 && rc >= -ONE30 && ps <= ONE30 && ps >= -ONE30), "CORDIC output outside unit range")
	`VER_ASSERT_NEXT(a_hold_valid, !en, $stable(vld_s4) && $stable(vld_c[CORDIC_LAT-1]), "pipeline valid moved during hold")

endmodule

/* rtl/ver_sincos.sv */
// Pipelined CORDIC giving cosine and sine of one binary angle per cycle while en is high.
module ver_sincos #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [ANGLE_WIDTH-1:0] angle,
	output ver_pkg::q30_t          cos_o,
	output ver_pkg::q30_t          sin_o
);
	import ver_pkg::*;

	logic signed [CX_W-1:0] x_s [0:CORDIC_STEPS];
	logic signed [CX_W-1:0] y_s [0:CORDIC_STEPS];
	logic signed [CZ_W-1:0] z_s [0:CORDIC_STEPS];
	logic [1:0]             quad_s [0:CORDIC_STEPS];
	logic [31:0]            phase;
	q30_t                   xc, yc;

	assign phase = {angle, {(32 - ANGLE_WIDTH){1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_K;
			y_s[0]    <= '0;
			z_s[0]    <= CZ_W'({2'b00, phase[29:0]});
			quad_s[0] <= phase[31:30];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[i+1] <= quad_s[i];
				if (!z_s[i][CZ_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - CZ_W'(ATAN[i]);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + CZ_W'(ATAN[i]);
				end
			end
		end
	end

	assign xc = clamp_unit(x_s[CORDIC_STEPS]);
	assign yc = clamp_unit(y_s[CORDIC_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s[CORDIC_STEPS])
				2'd0: begin
					cos_o <= xc;
					sin_o <= yc;
				end
				2'd1: begin
					cos_o <= -yc;
					sin_o <= xc;
				end
				2'd2: begin
					cos_o <= -xc;
					sin_o <= -yc;
				end
				default: begin
					cos_o <= yc;
					sin_o <= -xc;
				end
			endcase
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for vector_euler_rotation: predicted rotations vs. stream output.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_RANDOM = 1850;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;

	logic [143:0] pending_items[$];
	logic [95:0] expected_rot[$];
	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_total = 0;
	int cycles = 0;
	int tx_idle_pct = 24;
	int rx_idle_pct = 84;

	vector_euler_rotation u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint unit_clamp(input longint v);
		if (v > (64'sd1 <<< 30))
			return 64'sd1 <<< 30;
		if (v < -(64'sd1 <<< 30))
			return -(64'sd1 <<< 30);
		return v;
	endfunction

	function automatic void angle_cos_sin(input logic [15:0] a, output longint c,
			output longint s);
		logic [31:0] ph;
		longint x, y, z, dx, dy;
		ph = {a, 16'h0000};
		x = 652032874;
		y = 0;
		z = longint'(ph[29:0]);
		for (int i = 0; i < ver_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ver_pkg::ATAN[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ver_pkg::ATAN[i]);
			end
		end
		x = unit_clamp(x);
		y = unit_clamp(y);
		case (ph[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic longint qmul30(input longint a, input longint b);
		longint ma, mb, r;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		r = (ma * mb + (64'sd1 <<< 29)) >>> 30;
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic logic [31:0] column_dot(input longint m0, input longint m1,
			input longint m2, input longint v0, input longint v1, input longint v2);
		logic signed [127:0] acc;
		acc = 128'sd536870912;
		acc = acc + 128'(v0) * 128'(m0);
		acc = acc + 128'(v1) * 128'(m1);
		acc = acc + 128'(v2) * 128'(m2);
		acc = acc >>> 30;
		if (acc > 128'sd2147483647)
			return 32'h7fffffff;
		if (acc < -128'sd2147483648)
			return 32'h80000000;
		return acc[31:0];
	endfunction

	function automatic logic [95:0] rotate_vector(input logic [143:0] item);
		longint vx, vy, vz, rc, rs, pc, ps, yc, ys, t1, t2;
		logic [31:0] ox, oy, oz;
		vx = longint'($signed(item[31:0]));
		vy = longint'($signed(item[63:32]));
		vz = longint'($signed(item[95:64]));
		angle_cos_sin(item[111:96], rc, rs);
		angle_cos_sin(item[127:112], pc, ps);
		angle_cos_sin(item[143:128], yc, ys);
		t1 = qmul30(ys, ps);
		t2 = qmul30(yc, ps);
		ox = column_dot(unit_clamp(qmul30(yc, rc) + qmul30(t1, rs)),
			unit_clamp(qmul30(-yc, rs) + qmul30(t1, rc)),
			unit_clamp(qmul30(ys, pc)), vx, vy, vz);
		oy = column_dot(unit_clamp(qmul30(rs, pc)), unit_clamp(qmul30(rc, pc)),
			unit_clamp(-ps), vx, vy, vz);
		oz = column_dot(unit_clamp(qmul30(-ys, rc) + qmul30(t2, rs)),
			unit_clamp(qmul30(rs, ys) + qmul30(t2, rc)),
			unit_clamp(qmul30(yc, pc)), vx, vy, vz);
		return {oz, oy, ox};
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(131072)) - 65536);
			3: return 32'($signed($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(4))
			0: return 16'($urandom_range(3)) << 14;
			1: return (16'($urandom_range(3)) << 14) + 16'($urandom_range(4)) - 16'd2;
			default: return 16'($urandom);
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_rot.push_back(rotate_vector(s_axis_tdata));
			n_sent <= n_sent + 1;
		end
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				s_axis_tdata <= pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		logic [95:0] exp_v;
		m_axis_tready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_rot.size() == 0) begin
				n_errors <= n_errors + 1;
				$display("%0t unexpected transfer: actual %h", $time, m_axis_tdata);
			end else begin
				exp_v = expected_rot.pop_front();
				if (exp_v !== m_axis_tdata) begin
					n_errors <= n_errors + 1;
					if (n_errors < 20)
						$display("%0t expected %h (z,y,x) actual %h", $time, exp_v,
							m_axis_tdata);
				end
			end
			n_checked <= n_checked + 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("vector_euler_rotation: mismatch");
			$finish;
		end
		if (n_total > 0) begin
			if (n_sent < n_total / 3) begin
				tx_idle_pct <= 24;
				rx_idle_pct <= 84;
			end else if (n_sent < 2 * n_total / 3) begin
				tx_idle_pct <= 84;
				rx_idle_pct <= 24;
			end else begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end
		end
	end

	initial begin
		logic [31:0] cx[4];
		logic [15:0] an[8];
		cx = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h00010000};
		an = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h0001, 16'h3fff,
			16'h2000};
		for (int i = 0; i < 8; i++)
			pending_items.push_back({an[i], an[(i + 3) % 8], an[(i + 5) % 8],
				32'h00010000, 32'hffff0000, 32'h00020000});
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				pending_items.push_back({an[(i + j) % 8], an[i * 2], an[j * 2],
					cx[j], cx[(i + j) % 4], cx[i]});
		for (int i = 0; i < NUM_RANDOM; i++)
			pending_items.push_back({pick_angle(), pick_angle(), pick_angle(),
				pick_coord(), pick_coord(), pick_coord()});
		n_total = pending_items.size();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0 && !s_axis_tvalid && expected_rot.size() == 0);
		repeat (100) @(posedge clk);
		$display("%0d vectors sent (extremes, quadrant angles, random), %0d results checked",
			n_sent, n_checked);
		$display("sender/receiver stalls swept through three idle mixes");
		if (n_errors == 0 && expected_rot.size() == 0)
			$display("vector_euler_rotation: match");
		else
			$display("vector_euler_rotation: mismatch");
		$finish;
	end
endmodule
